@@ rtl/core/wpad_pkg.sv @@
// shared types, widths and helpers of the peak/average waveform decimator
// no dependencies; used by the interfaces and every module in rtl/core
`default_nettype none

package wpad_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 16;
  localparam int CFG_BITS    = 16;
  // magnitude sum of a full block of samples
  localparam int SUM_BITS    = SAMPLE_BITS - 1 + COUNT_BITS;
  localparam int LIM_BITS    = (CFG_BITS > COUNT_BITS) ? CFG_BITS : COUNT_BITS;
  localparam int STEP_BITS   = $clog2(SAMPLE_BITS + 1);

  localparam logic [COUNT_BITS-1:0]  CNT_MAX   = '1;
  localparam logic [SAMPLE_BITS-1:0] SMIN_VAL  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
  localparam logic [SAMPLE_BITS-1:0] SMAX_VAL  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic [CFG_BITS-1:0]    BLOCK_RST = CFG_BITS'(1);

  typedef enum logic [2:0] {
    ST_ACCUM,
    ST_POS_GO,
    ST_POS_RUN,
    ST_NEG_GO,
    ST_NEG_RUN,
    ST_EMIT
  } wpad_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;
    logic div_start;
    logic div_sel_neg;
    logic save_pos;
    logic save_neg;
    logic load_out;
  } wpad_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic block_end;
    logic div_done;
    logic out_free;
  } wpad_stat_t;

  // zero acts as one, values past the counter range saturate
  function automatic logic [COUNT_BITS-1:0] eff_limit(input logic [CFG_BITS-1:0] bs);
    logic [LIM_BITS-1:0] wide;
    wide = LIM_BITS'(bs);
    if (wide == '0) begin
      wide = LIM_BITS'(1);
    end
    if (wide > LIM_BITS'(CNT_MAX)) begin
      wide = LIM_BITS'(CNT_MAX);
    end
    return wide[COUNT_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/wpad_sample_if.sv @@
// sample channel: valid/ready handshake carrying one audio sample
// depends on wpad_pkg
`default_nettype none

interface wpad_sample_if
  import wpad_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wpad_result_if.sv @@
// result channel: valid/ready handshake carrying one block summary
// depends on wpad_pkg
`default_nettype none

interface wpad_result_if
  import wpad_pkg::*;
;
  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] peak_max;
  logic signed [SAMPLE_BITS-1:0] peak_min;
  logic        [SAMPLE_BITS-2:0] mean_positive;
  logic signed [SAMPLE_BITS-1:0] mean_negative;

  modport source (output valid, output peak_max, output peak_min,
                  output mean_positive, output mean_negative, input ready);
  modport sink   (input valid, input peak_max, input peak_min,
                  input mean_positive, input mean_negative, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wpad_cfg_if.sv @@
// configuration write channel: valid/ready handshake carrying block_size
// depends on wpad_pkg
`default_nettype none

interface wpad_cfg_if
  import wpad_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CFG_BITS-1:0] block_size;

  modport source (output valid, output block_size, input ready);
  modport sink   (input valid, input block_size, output ready);
endinterface

`default_nettype wire

@@ rtl/core/wpad_div.sv @@
// serial restoring divider, one quotient bit per cycle
// depends on wpad_pkg; quotient is known to fit SAMPLE_BITS bits
`default_nettype none

module wpad_div
  import wpad_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  input  wire logic [SUM_BITS-1:0]    dividend,
  input  wire logic [COUNT_BITS-1:0]  divisor,
  output logic                        done,
  output logic      [SAMPLE_BITS-1:0] quotient
);

  logic [COUNT_BITS-1:0]  rem;
  logic [COUNT_BITS-1:0]  dvs;
  logic [SAMPLE_BITS-1:0] shq;
  logic [STEP_BITS-1:0]   steps;
  logic [COUNT_BITS:0]    trial;
  logic                   fits;

  assign trial    = {rem, shq[SAMPLE_BITS-1]};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = shq;

  always_ff @(posedge clk) begin
    if (rst) begin
      steps <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        steps <= STEP_BITS'(SAMPLE_BITS);
      end else if (steps != '0) begin
        steps <= steps - STEP_BITS'(1);
        done  <= (steps == STEP_BITS'(1));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // upper dividend bits are already below the divisor
      rem <= COUNT_BITS'(dividend[SUM_BITS-1:SAMPLE_BITS]);
      shq <= dividend[SAMPLE_BITS-1:0];
      dvs <= divisor;
    end else if (steps != '0) begin
      rem <= fits ? COUNT_BITS'(trial - {1'b0, dvs}) : trial[COUNT_BITS-1:0];
      shq <= {shq[SAMPLE_BITS-2:0], fits};
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/wpad_ctrl.sv @@
// controller state machine: accumulate, two divisions, emit
// depends on wpad_pkg
`default_nettype none

module wpad_ctrl
  import wpad_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire wpad_stat_t stat,
  output wpad_cmd_t       cmd
);

  wpad_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCUM;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_ACCUM: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
        if (in_valid && stat.block_end) begin
          state_next = ST_POS_GO;
        end
      end
      ST_POS_GO: begin
        cmd.div_start = 1'b1;
        state_next    = ST_POS_RUN;
      end
      ST_POS_RUN: begin
        if (stat.div_done) begin
          cmd.save_pos = 1'b1;
          state_next   = ST_NEG_GO;
        end
      end
      ST_NEG_GO: begin
        cmd.div_start   = 1'b1;
        cmd.div_sel_neg = 1'b1;
        state_next      = ST_NEG_RUN;
      end
      ST_NEG_RUN: begin
        cmd.div_sel_neg = 1'b1;
        if (stat.div_done) begin
          cmd.save_neg = 1'b1;
          state_next   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_ACCUM;
        end
      end
      default: begin
        state_next = ST_ACCUM;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/wpad_dp.sv @@
// datapath: block accumulators, snapshot, shared divider, output register
// depends on wpad_pkg and wpad_div
`default_nettype none

module wpad_dp
  import wpad_pkg::*;
(
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire wpad_cmd_t                     cmd,
  output wpad_stat_t                         stat,
  input  wire logic                          cfg_valid,
  input  wire logic        [CFG_BITS-1:0]    cfg_data,
  input  wire logic signed [SAMPLE_BITS-1:0] sample,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic signed      [SAMPLE_BITS-1:0] peak_max,
  output logic signed      [SAMPLE_BITS-1:0] peak_min,
  output logic             [SAMPLE_BITS-2:0] mean_positive,
  output logic signed      [SAMPLE_BITS-1:0] mean_negative
);

  logic [CFG_BITS-1:0] block_size;

  // running block state
  logic signed [SAMPLE_BITS-1:0] run_max, run_min;
  logic [SUM_BITS-1:0]           pos_sum, neg_sum;
  logic [COUNT_BITS-1:0]         pos_cnt, neg_cnt, seen;

  // values after the current sample
  logic signed [SAMPLE_BITS-1:0] max_next, min_next;
  logic [SUM_BITS-1:0]           pos_sum_next, neg_sum_next;
  logic [COUNT_BITS-1:0]         pos_cnt_next, neg_cnt_next;
  logic [COUNT_BITS:0]           seen_next;
  logic                          is_pos, is_neg;
  logic [SAMPLE_BITS-1:0]        mag;

  // snapshot of a finished block
  logic signed [SAMPLE_BITS-1:0] snap_max, snap_min;
  logic [SUM_BITS-1:0]           snap_psum, snap_nsum;
  logic [COUNT_BITS-1:0]         snap_pcnt, snap_ncnt;
  logic [SAMPLE_BITS-2:0]        mpos;
  logic [SAMPLE_BITS-1:0]        mneg;

  logic                   div_done;
  logic [SAMPLE_BITS-1:0] quot;

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size <= BLOCK_RST;
    end else if (cfg_valid) begin
      block_size <= cfg_data;
    end
  end

  always_comb begin
    is_neg       = sample[SAMPLE_BITS-1];
    is_pos       = !is_neg && (sample != '0);
    mag          = is_neg ? SAMPLE_BITS'(-sample) : '0;
    max_next     = (sample > run_max) ? sample : run_max;
    min_next     = (sample < run_min) ? sample : run_min;
    pos_sum_next = pos_sum + (is_pos ? SUM_BITS'(unsigned'(sample)) : '0);
    neg_sum_next = neg_sum + SUM_BITS'(mag);
    pos_cnt_next = pos_cnt + COUNT_BITS'(is_pos);
    neg_cnt_next = neg_cnt + COUNT_BITS'(is_neg);
    seen_next    = {1'b0, seen} + (COUNT_BITS+1)'(1);
  end

  assign stat.block_end = seen_next >= {1'b0, eff_limit(block_size)};
  assign stat.div_done  = div_done;
  assign stat.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      run_max <= SMIN_VAL;
      run_min <= SMAX_VAL;
      pos_sum <= '0;
      neg_sum <= '0;
      pos_cnt <= '0;
      neg_cnt <= '0;
      seen    <= '0;
    end else if (cmd.take) begin
      if (stat.block_end) begin
        run_max <= SMIN_VAL;
        run_min <= SMAX_VAL;
        pos_sum <= '0;
        neg_sum <= '0;
        pos_cnt <= '0;
        neg_cnt <= '0;
        seen    <= '0;
      end else begin
        run_max <= max_next;
        run_min <= min_next;
        pos_sum <= pos_sum_next;
        neg_sum <= neg_sum_next;
        pos_cnt <= pos_cnt_next;
        neg_cnt <= neg_cnt_next;
        seen    <= seen_next[COUNT_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take && stat.block_end) begin
      snap_max  <= max_next;
      snap_min  <= min_next;
      snap_psum <= pos_sum_next;
      snap_nsum <= neg_sum_next;
      snap_pcnt <= pos_cnt_next;
      snap_ncnt <= neg_cnt_next;
    end
    if (cmd.save_pos) begin
      mpos <= (snap_pcnt == '0) ? '0 : quot[SAMPLE_BITS-2:0];
    end
    if (cmd.save_neg) begin
      mneg <= (snap_ncnt == '0) ? '0 : SAMPLE_BITS'(-quot);
    end
  end

  wpad_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (cmd.div_sel_neg ? snap_nsum : snap_psum),
    .divisor  (cmd.div_sel_neg ? snap_ncnt : snap_pcnt),
    .done     (div_done),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      peak_max      <= snap_max;
      peak_min      <= snap_min;
      mean_positive <= mpos;
      mean_negative <= mneg;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/waveform_peak_average_decimator.sv @@
// peak/average decimator: one sample per cycle while a block fills; at the
// block end it runs two 16-step serial divisions on the shared divider and
// loads the result into an output register, then takes the next sample; a
// waiting result blocks only the next block end; rst (synchronous) sets
// block_size to 1 and clears the controller, accumulators and out_valid
`default_nettype none

module waveform_peak_average_decimator
  import wpad_pkg::*;
(
  input wire logic  clk,
  input wire logic  rst,
  wpad_cfg_if.sink      cfg,
  wpad_sample_if.sink   samples,
  wpad_result_if.source results
);

  wpad_cmd_t  cmd;
  wpad_stat_t stat;

  // block_size can be written any time the block is idle
  assign cfg.ready = 1'b1;

  // sequencing: accumulate, positive mean, negative mean, emit
  wpad_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (samples.valid),
    .in_ready (samples.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // accumulators, divider and output register
  wpad_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .cfg_valid     (cfg.valid),
    .cfg_data      (cfg.block_size),
    .sample        (samples.sample),
    .out_valid     (results.valid),
    .out_ready     (results.ready),
    .peak_max      (results.peak_max),
    .peak_min      (results.peak_min),
    .mean_positive (results.mean_positive),
    .mean_negative (results.mean_negative)
  );

endmodule

`default_nettype wire

@@ test/tb_waveform_peak_average_decimator.sv @@
// self-checking testbench for waveform_peak_average_decimator: random-gap driver and monitor,
// in-bench block summary predictor, block_size sweeps including zero and full counter range
// depends on wpad_pkg, the three channel interfaces and the decimator top level
`timescale 1ns / 100ps

module tb_waveform_peak_average_decimator;
  import wpad_pkg::*;

  // cycles the block may still be busy after the last summary came out
  localparam int DRAIN_TAIL     = 50;
  // receiver hold-off used to back the block up
  localparam int RX_HOLD_CYCLES = 600;
  // cycles without any item moving before the run is abandoned
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RAND_ITEMS     = 1350;
  localparam int FULL_BLOCK     = 65535;
  // samples sent into the open block while block_size is at the counter top
  localparam int LONG_RUN       = 200;

  typedef enum {
    OP_SAMPLE,
    OP_CONFIG,
    OP_DRAIN,
    OP_HOLD_RX,
    OP_CALM,
    OP_END
  } stim_kind_t;

  typedef enum {
    MIX_ANY,
    MIX_EXTREME,
    MIX_NEAR_ZERO,
    MIX_POSITIVE,
    MIX_NEGATIVE
  } sample_mix_t;

  typedef struct {
    stim_kind_t            kind;
    logic [SAMPLE_BITS-1:0] smp;
    logic [CFG_BITS-1:0]    cfg_val;
  } stim_op_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] peak_max;
    logic signed [SAMPLE_BITS-1:0] peak_min;
    logic        [SAMPLE_BITS-2:0] mean_pos;
    logic signed [SAMPLE_BITS-1:0] mean_neg;
  } summary_t;

  logic clk;
  logic rst;

  wpad_cfg_if    cfg_if ();
  wpad_sample_if smp_if ();
  wpad_result_if res_if ();

  waveform_peak_average_decimator uut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_if),
    .samples (smp_if),
    .results (res_if)
  );

  // pending stimulus and the summaries the block owes us
  stim_op_t stim_q[$];
  summary_t pending_summaries[$];

  // predictor copy of the block's register and accumulators
  logic        [CFG_BITS-1:0]    blk_size;
  logic signed [SAMPLE_BITS-1:0] pk_hi;
  logic signed [SAMPLE_BITS-1:0] pk_lo;
  logic        [31:0]            pos_sum;
  logic        [31:0]            neg_sum;
  int unsigned                   pos_cnt;
  int unsigned                   neg_cnt;
  int unsigned                   seen_cnt;

  // driver / receiver coordination
  bit          calm          = 1'b0;
  bit          rx_hold_req   = 1'b0;
  bit          stim_finished = 1'b0;
  bit          draining;
  int unsigned gap_left;
  int unsigned tail_left;
  int unsigned hold_left;
  int unsigned stall_left;
  int          idle_cycles   = 0;
  int          err_count     = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    err_count++;
  endtask

  // mostly short gaps, a few long ones, none while in a calm stretch
  function automatic int unsigned pick_gap();
    int unsigned r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(input sample_mix_t mix);
    case (mix)
      MIX_ANY: begin
        return SAMPLE_BITS'($urandom);
      end
      MIX_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return SMAX_VAL;
          1: return SMIN_VAL;
          2: return '0;
          3: return SAMPLE_BITS'(1);
          default: return '1;
        endcase
      end
      MIX_NEAR_ZERO: begin
        return SAMPLE_BITS'(int'($urandom_range(0, 16)) - 8);
      end
      MIX_POSITIVE: begin
        return SAMPLE_BITS'($urandom_range(1, 32767));
      end
      default: begin
        return SAMPLE_BITS'(-int'($urandom_range(1, 32768)));
      end
    endcase
  endfunction

  // accumulators back to their idle values, after reset and after each summary
  function automatic void clear_block_state();
    pk_hi    = SMIN_VAL;
    pk_lo    = SMAX_VAL;
    pos_sum  = '0;
    neg_sum  = '0;
    pos_cnt  = 0;
    neg_cnt  = 0;
    seen_cnt = 0;
  endfunction

  // folds one sample into the running block; returns 1 with the summary at block end
  function automatic bit fold_sample(input logic signed [SAMPLE_BITS-1:0] s,
                                     output summary_t sm);
    int          sv;
    int unsigned lim;
    logic [31:0] mag;
    sv  = s;
    lim = blk_size;
    sm  = '0;
    // zero block size behaves as one, oversize saturates at the counter
    if (lim == 0) begin
      lim = 1;
    end
    if (lim > CNT_MAX) begin
      lim = CNT_MAX;
    end
    // max and min are both checked on every sample
    if (s > pk_hi) begin
      pk_hi = s;
    end
    if (s < pk_lo) begin
      pk_lo = s;
    end
    // zero counts as neither sign
    if (sv > 0) begin
      pos_cnt++;
      pos_sum = pos_sum + 32'(sv);
    end else if (sv < 0) begin
      neg_cnt++;
      neg_sum = neg_sum + 32'(-sv);
    end
    seen_cnt++;
    // a lowered block size fires as soon as the count reaches or passes it
    if (seen_cnt < lim) begin
      return 1'b0;
    end
    sm.peak_max = pk_hi;
    sm.peak_min = pk_lo;
    if (pos_cnt > 0) begin
      mag         = pos_sum / pos_cnt;
      sm.mean_pos = mag[SAMPLE_BITS-2:0];
    end
    // negative mean from the magnitude, so it truncates toward zero
    if (neg_cnt > 0) begin
      mag         = neg_sum / neg_cnt;
      sm.mean_neg = SAMPLE_BITS'(32'd0 - mag);
    end
    clear_block_state();
    return 1'b1;
  endfunction

  task automatic add_op(input stim_kind_t kind, input logic [CFG_BITS-1:0] val);
    stim_op_t op;
    op.kind    = kind;
    op.smp     = '0;
    op.cfg_val = val;
    stim_q.push_back(op);
  endtask

  task automatic add_sample(input logic signed [SAMPLE_BITS-1:0] v);
    stim_op_t op;
    op.kind    = OP_SAMPLE;
    op.smp     = v;
    op.cfg_val = '0;
    stim_q.push_back(op);
  endtask

  // register writes only once the block has gone quiet
  task automatic add_config(input logic [CFG_BITS-1:0] val);
    add_op(OP_DRAIN, '0);
    add_op(OP_CONFIG, val);
  endtask

  // sender: presents one item at a time from stim_q, gaps between items
  always @(posedge clk) begin : sample_driver
    stim_op_t op;
    summary_t sm;
    logic     nxt_sv;
    logic     nxt_cv;
    nxt_sv = smp_if.valid;
    nxt_cv = cfg_if.valid;
    if (rst) begin
      nxt_sv   = 1'b0;
      nxt_cv   = 1'b0;
      gap_left = 0;
      draining = 1'b0;
      blk_size = BLOCK_RST;
      clear_block_state();
    end else begin
      // accepted sample item: predict right away
      if (smp_if.valid && smp_if.ready) begin
        if (fold_sample(smp_if.sample, sm)) begin
          pending_summaries.push_back(sm);
        end
        nxt_sv = 1'b0;
      end
      if (cfg_if.valid && cfg_if.ready) begin
        blk_size = cfg_if.block_size;
        nxt_cv   = 1'b0;
      end
      if (!nxt_sv && !nxt_cv) begin
        if (draining) begin
          // pause until every summary is in, then let the block settle
          if (pending_summaries.size() == 0) begin
            if (tail_left > 0) begin
              tail_left--;
            end else begin
              draining = 1'b0;
            end
          end
        end else if (gap_left > 0) begin
          gap_left--;
        end else if (stim_q.size() > 0) begin
          op = stim_q.pop_front();
          case (op.kind)
            OP_SAMPLE: begin
              smp_if.sample <= op.smp;
              nxt_sv   = 1'b1;
              gap_left = pick_gap();
            end
            OP_CONFIG: begin
              cfg_if.block_size <= op.cfg_val;
              nxt_cv = 1'b1;
            end
            OP_DRAIN: begin
              draining  = 1'b1;
              tail_left = DRAIN_TAIL;
            end
            OP_HOLD_RX: begin
              rx_hold_req = 1'b1;
            end
            OP_CALM: begin
              calm = op.cfg_val[0];
            end
            default: begin
              stim_finished = 1'b1;
            end
          endcase
        end
      end
    end
    smp_if.valid <= nxt_sv;
    cfg_if.valid <= nxt_cv;
  end

  // receiver: random ready stalls, one long hold on request, checks each summary item
  always @(posedge clk) begin : result_monitor
    summary_t want;
    logic     nxt_rdy;
    if (rst) begin
      nxt_rdy    = 1'b0;
      hold_left  = 0;
      stall_left = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (pending_summaries.size() == 0) begin
          report_error("summary item arrived with none expected");
        end else begin
          want = pending_summaries.pop_front();
          if (res_if.peak_max !== want.peak_max) begin
            report_error($sformatf("peak_max got %0d want %0d",
                                   res_if.peak_max, want.peak_max));
          end
          if (res_if.peak_min !== want.peak_min) begin
            report_error($sformatf("peak_min got %0d want %0d",
                                   res_if.peak_min, want.peak_min));
          end
          if (res_if.mean_positive !== want.mean_pos) begin
            report_error($sformatf("mean_positive got %0d want %0d",
                                   res_if.mean_positive, want.mean_pos));
          end
          if (res_if.mean_negative !== want.mean_neg) begin
            report_error($sformatf("mean_negative got %0d want %0d",
                                   res_if.mean_negative, want.mean_neg));
          end
        end
        if ($urandom_range(0, 3) == 0) begin
          stall_left = pick_gap();
        end
      end
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        hold_left   = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        nxt_rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nxt_rdy = 1'b0;
      end else begin
        nxt_rdy = 1'b1;
        // stalls also land while the block is still working
        if ($urandom_range(0, 9) == 0) begin
          stall_left = pick_gap();
        end
      end
    end
    res_if.ready <= nxt_rdy;
  end

  // cycles in which no item moved on any channel
  always @(posedge clk) begin
    if (rst || (smp_if.valid && smp_if.ready) || (cfg_if.valid && cfg_if.ready) ||
        (res_if.valid && res_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : main_seq
    int          n_rand;
    int          eff;
    int          nblk;
    int          k;
    int unsigned r;
    int unsigned bs;
    bit          hold_done;
    sample_mix_t mix;

    rst               = 1'b1;
    smp_if.valid      = 1'b0;
    smp_if.sample     = '0;
    cfg_if.valid      = 1'b0;
    cfg_if.block_size = BLOCK_RST;
    res_if.ready      = 1'b0;

    // reset block size of one: each sample is its own summary,
    // single-sign blocks leave the other sign's mean at zero
    add_sample(SMAX_VAL);
    add_sample(SMIN_VAL);
    add_sample(16'sd0);
    add_sample(16'sd1);
    add_sample(-16'sd1);
    // zero block size acts as one; alternating bit patterns
    add_config(16'd0);
    add_sample(16'sh5555);
    add_sample(16'shAAAA);
    // full-scale block, then a block with no signed samples at all
    add_config(16'd4);
    add_sample(SMAX_VAL);
    add_sample(SMAX_VAL);
    add_sample(SMIN_VAL);
    add_sample(SMIN_VAL);
    repeat (4) add_sample(16'sd0);
    // block size lowered mid-block: fires on the next sample
    add_config(16'd5);
    add_sample(16'sd1);
    add_sample(16'sd2);
    add_sample(16'sd4);
    add_config(16'd2);
    add_sample(16'sd7);
    // means that truncate: 5/3 down to 1, -5/3 toward zero to -1
    add_config(16'd3);
    add_sample(16'sd1);
    add_sample(16'sd2);
    add_sample(16'sd2);
    add_sample(-16'sd1);
    add_sample(-16'sd2);
    add_sample(-16'sd2);

    // block size at the top of the counter range, back to back, heavy on full scale;
    // lowering it afterwards makes the long open block fire on the next sample
    add_config(16'(FULL_BLOCK));
    add_op(OP_CALM, 16'd1);
    for (int j = 0; j < LONG_RUN; j++) begin
      r = $urandom_range(0, 15);
      if (r < 11) begin
        add_sample(SMAX_VAL);
      end else if (r < 15) begin
        add_sample(SMIN_VAL);
      end else begin
        add_sample(pick_sample(MIX_ANY));
      end
    end
    add_op(OP_CALM, 16'd0);
    add_config(16'd1);
    add_sample(pick_sample(MIX_ANY));

    // random part: well-formed blocks with random content, some cut short
    n_rand    = 0;
    hold_done = 1'b0;
    while (n_rand < RAND_ITEMS) begin
      if (!hold_done && n_rand > RAND_ITEMS / 2) begin
        // receiver holds off while one-sample blocks keep coming, so the block backs up
        add_config(16'd1);
        add_op(OP_HOLD_RX, '0);
        repeat (40) add_sample(pick_sample(MIX_ANY));
        n_rand   += 40;
        hold_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 60) begin
        bs = $urandom_range(1, 6);
      end else if (r < 90) begin
        bs = $urandom_range(7, 40);
      end else if (r < 95) begin
        bs = 0;
      end else begin
        bs = $urandom_range(41, 100);
      end
      add_config(16'(bs));
      if ($urandom_range(0, 4) == 0) begin
        add_op(OP_CALM, 16'($urandom_range(0, 1)));
      end
      eff  = (bs == 0) ? 1 : bs;
      nblk = (eff > 40) ? 1 : $urandom_range(1, 5);
      for (int b = 0; b < nblk; b++) begin
        mix = sample_mix_t'($urandom_range(0, 4));
        for (int j = 0; j < eff; j++) begin
          add_sample(pick_sample(mix));
        end
        n_rand += eff;
      end
      r = $urandom_range(0, 9);
      if (r < 2) begin
        // partial block left open across the next size change
        k = $urandom_range(0, eff - 1);
        for (int j = 0; j < k; j++) begin
          add_sample(pick_sample(MIX_ANY));
        end
        n_rand += k;
      end else if (r < 3) begin
        // sender waits until every summary is back
        add_op(OP_DRAIN, '0);
      end
    end
    add_op(OP_CALM, 16'd0);
    add_op(OP_DRAIN, '0);
    add_op(OP_END, '0);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // the closing drain already waited for the last summary plus settle time
    wait (stim_finished);
    if (err_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/wpad_pkg.sv
rtl/core/wpad_sample_if.sv
rtl/core/wpad_result_if.sv
rtl/core/wpad_cfg_if.sv
rtl/core/wpad_div.sv
rtl/core/wpad_ctrl.sv
rtl/core/wpad_dp.sv
rtl/core/waveform_peak_average_decimator.sv
test/tb_waveform_peak_average_decimator.sv
